FILE: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, payload types, register indexes and normal constants for
// the rectangle signed-distance block.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// Coordinate width of points and rectangle edges (signed Q12.12).
	localparam int COORD_BITS = 24;

	// Derived widths of the doubled-coordinate datapath.
	localparam int DIFF_BITS = COORD_BITS + 2;   // 2*p - (min + max)
	localparam int HALF_BITS = COORD_BITS + 1;   // max - min
	localparam int EX_BITS   = COORD_BITS + 3;   // |2*p - c2| - h2
	localparam int MAG_BITS  = COORD_BITS + 1;   // positive excess in a corner
	localparam int SQ_BITS   = 2 * MAG_BITS;
	localparam int SUM_BITS  = SQ_BITS + 1;
	localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 3;
	localparam int DIST_BITS = COORD_BITS + 2;
	localparam int NORM_BITS = 16;

	// Outward normals in Q1.14.
	localparam logic signed [NORM_BITS-1:0] NORM_ONE    = NORM_BITS'(16384);
	localparam logic signed [NORM_BITS-1:0] NORM_ONE_N  = -NORM_BITS'(16384);
	localparam logic signed [NORM_BITS-1:0] NORM_DIAG   = NORM_BITS'(11585);
	localparam logic signed [NORM_BITS-1:0] NORM_DIAG_N = -NORM_BITS'(11585);
	localparam logic signed [NORM_BITS-1:0] NORM_ZERO   = '0;

	// Reset values of the rectangle edges.
	localparam logic signed [COORD_BITS-1:0] EDGE_MIN_RST = '0;
	localparam logic signed [COORD_BITS-1:0] EDGE_MAX_RST = COORD_BITS'(4096);

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_MIN = 2'd0,
		REG_Y_MIN = 2'd1,
		REG_X_MAX = 2'd2,
		REG_Y_MAX = 2'd3
	} cfg_reg_t;

	// Input beat: the query point.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} in_t;

	// Output beat: distance, exit point and outward normal.
	typedef struct packed {
		logic signed [DIST_BITS-1:0]  distance;
		logic signed [COORD_BITS-1:0] exit_x;
		logic signed [COORD_BITS-1:0] exit_y;
		logic signed [NORM_BITS-1:0]  normal_x;
		logic signed [NORM_BITS-1:0]  normal_y;
	} out_t;

	// Side information that rides along the square-root pipeline.
	typedef struct packed {
		logic corner;
		out_t res;
	} sq_tag_t;

endpackage

FILE: rtl/rsd_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rsd_sqrt_pipe
// Fully pipelined floor square root, one result bit per stage, with a tag
// and a valid bit that travel alongside the data under a common enable.
// ----------------------------------------------------------------------------
module rsd_sqrt_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [rsd_pkg::RAD_BITS-1:0]   radicand,
	input  rsd_pkg::sq_tag_t               in_tag,
	output logic                           out_valid,
	output logic [rsd_pkg::ROOT_BITS-1:0]  root,
	output rsd_pkg::sq_tag_t               out_tag
);
	import rsd_pkg::*;

	// Per-stage registers: remaining radicand, partial remainder and root.
	logic [RAD_BITS-1:0]  rad_s  [ROOT_BITS];
	logic [REM_BITS-1:0]  rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [ROOT_BITS];
	logic                 vld_s  [ROOT_BITS];
	sq_tag_t              tag_s  [ROOT_BITS];

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
		logic [RAD_BITS-1:0]  rad_in;
		logic [REM_BITS-1:0]  rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic                 vld_in;
		sq_tag_t              tag_in;
		logic [REM_BITS-1:0]  rem_sh;
		logic [REM_BITS-1:0]  trial;

		// The first stage starts from an empty remainder and root.
		if (k == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign vld_in  = in_valid;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign vld_in  = vld_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		// Bring down the next two radicand bits and try a one in this position.
		assign rem_sh = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_in[RAD_BITS-3:0], 2'b00};
				tag_s[k] <= tag_in;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_in[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_in[ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_BITS-1];
	assign root      = root_s[ROOT_BITS-1];
	assign out_tag   = tag_s[ROOT_BITS-1];

endmodule

FILE: rtl/rsd_out_skid.sv
// ----------------------------------------------------------------------------
// rsd_out_skid
// Output register with one skid entry. The upstream ready comes from a
// flop, so a stalled receiver never reaches back combinationally.
// ----------------------------------------------------------------------------
module rsd_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  rsd_pkg::out_t push_data,
	output logic          push_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rsd_pkg::out_t out_data
);
	import rsd_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	out_t out_data_q;
	out_t skid_data_q;
	logic push;
	logic pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign pop        = out_valid_q && out_ready;

	// Valid bits of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					out_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload moves; the skid entry drains first so order is kept.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/rect_signed_distance_exit.sv
// ----------------------------------------------------------------------------
// rect_signed_distance_exit
// Signed distance from a point to an axis-aligned rectangle, with the
// nearest boundary point and an outward normal.
// ----------------------------------------------------------------------------
// Usage:
// Rectangle edges are written on the cfg channel (index 0 x_min, 1 y_min,
// 2 x_max, 3 y_max); cfg_ready is always high. Write them only while no
// point is in flight.
// Each input beat carries one point and produces exactly one output beat,
// in order. The block takes one point per cycle unless the pipeline is
// frozen. A result passes through four arithmetic stages, a 26-stage floor
// square root that retires one root bit per stage, and the output register.
// When the receiver stalls, the result waits in the output register and
// one more in a skid entry; once the skid entry is full the whole pipeline
// freezes and in_ready drops with it, so nothing is lost.
// Reset clears all valid bits and sets the rectangle to [0, 1.0] on both
// axes.
// ----------------------------------------------------------------------------
module rect_signed_distance_exit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rsd_pkg::COORD_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  rsd_pkg::in_t                         in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output rsd_pkg::out_t                        out_data
);
	import rsd_pkg::*;

	// Rectangle edge registers.
	logic signed [COORD_BITS-1:0] x_min_q, y_min_q, x_max_q, y_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= EDGE_MIN_RST;
			y_min_q <= EDGE_MIN_RST;
			x_max_q <= EDGE_MAX_RST;
			y_max_q <= EDGE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_MIN: x_min_q <= $signed(cfg_data);
				REG_Y_MIN: y_min_q <= $signed(cfg_data);
				REG_X_MAX: x_max_q <= $signed(cfg_data);
				REG_Y_MAX: y_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Pipeline enable, shared by every stage.
	logic en;
	logic push_ready;

	assign en       = push_ready;
	assign in_ready = en;

	// Stage 1: doubled offset from the centre and doubled half-size.
	logic signed [DIFF_BITS-1:0]  cx2_w, cy2_w, diffx_w, diffy_w;
	logic signed [HALF_BITS-1:0]  hx2_w, hy2_w;
	logic                         v_s1;
	logic signed [DIFF_BITS-1:0]  diffx_s1, diffy_s1;
	logic signed [HALF_BITS-1:0]  hx2_s1, hy2_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1;

	assign cx2_w   = DIFF_BITS'(x_min_q) + DIFF_BITS'(x_max_q);
	assign cy2_w   = DIFF_BITS'(y_min_q) + DIFF_BITS'(y_max_q);
	assign diffx_w = (DIFF_BITS'(in_data.point_x) <<< 1) - cx2_w;
	assign diffy_w = (DIFF_BITS'(in_data.point_y) <<< 1) - cy2_w;
	assign hx2_w   = HALF_BITS'(x_max_q) - HALF_BITS'(x_min_q);
	assign hy2_w   = HALF_BITS'(y_max_q) - HALF_BITS'(y_min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diffx_s1 <= diffx_w;
			diffy_s1 <= diffy_w;
			hx2_s1   <= hx2_w;
			hy2_s1   <= hy2_w;
			px_s1    <= in_data.point_x;
			py_s1    <= in_data.point_y;
		end
	end

	// Stage 2: quadrant, excess beyond the half-size and the facing sides.
	logic [DIFF_BITS-1:0]         dxm_w, dym_w;
	logic signed [EX_BITS-1:0]    ex2_w, ey2_w;
	logic                         right_w, up_w;
	logic                         v_s2;
	logic signed [EX_BITS-1:0]    ex2_s2, ey2_s2;
	logic                         right_s2, up_s2;
	logic signed [COORD_BITS-1:0] side_x_s2, side_y_s2, px_s2, py_s2;

	assign dxm_w   = diffx_s1[DIFF_BITS-1] ? DIFF_BITS'(-diffx_s1) : DIFF_BITS'(diffx_s1);
	assign dym_w   = diffy_s1[DIFF_BITS-1] ? DIFF_BITS'(-diffy_s1) : DIFF_BITS'(diffy_s1);
	assign ex2_w   = $signed(EX_BITS'(dxm_w)) - EX_BITS'(hx2_s1);
	assign ey2_w   = $signed(EX_BITS'(dym_w)) - EX_BITS'(hy2_s1);
	// A point on a centre line counts as left or below.
	assign right_w = !diffx_s1[DIFF_BITS-1] && (diffx_s1 != '0);
	assign up_w    = !diffy_s1[DIFF_BITS-1] && (diffy_s1 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex2_s2    <= ex2_w;
			ey2_s2    <= ey2_w;
			right_s2  <= right_w;
			up_s2     <= up_w;
			side_x_s2 <= right_w ? x_max_q : x_min_q;
			side_y_s2 <= up_w ? y_max_q : y_min_q;
			px_s2     <= px_s1;
			py_s2     <= py_s1;
		end
	end

	// Stage 3: region decision, linear distance and the corner squares.
	logic                 xout_w, yout_w, ex_gt_ey_w;
	logic                 corner_w, xside_w, yside_w;
	logic [MAG_BITS-1:0]  a_w, b_w;
	logic [SQ_BITS-1:0]   sq_a_w, sq_b_w;
	out_t                 res_w;
	logic                 v_s3;
	logic [SQ_BITS-1:0]   sq_a_s3, sq_b_s3;
	sq_tag_t              tag_s3;

	assign xout_w     = !ex2_s2[EX_BITS-1] && (ex2_s2 != '0);
	assign yout_w     = !ey2_s2[EX_BITS-1] && (ey2_s2 != '0);
	assign ex_gt_ey_w = ex2_s2 > ey2_s2;
	assign corner_w   = xout_w && yout_w;
	// Inside, a tie goes to the top or bottom side.
	assign xside_w    = (xout_w && !yout_w) || (!xout_w && !yout_w && ex_gt_ey_w);
	assign yside_w    = !corner_w && !xside_w;
	// Both excesses are even; halving is a plain shift.
	assign a_w        = ex2_s2[MAG_BITS:1];
	assign b_w        = ey2_s2[MAG_BITS:1];
	assign sq_a_w     = a_w * a_w;
	assign sq_b_w     = b_w * b_w;

	always_comb begin
		res_w.distance = xside_w ? ex2_s2[DIST_BITS:1] : ey2_s2[DIST_BITS:1];
		res_w.exit_x   = yside_w ? px_s2 : side_x_s2;
		res_w.exit_y   = xside_w ? py_s2 : side_y_s2;
		res_w.normal_x = NORM_ZERO;
		res_w.normal_y = NORM_ZERO;
		if (corner_w) begin
			res_w.normal_x = right_s2 ? NORM_DIAG : NORM_DIAG_N;
			res_w.normal_y = up_s2 ? NORM_DIAG : NORM_DIAG_N;
		end else if (xside_w) begin
			res_w.normal_x = right_s2 ? NORM_ONE : NORM_ONE_N;
		end else begin
			res_w.normal_y = up_s2 ? NORM_ONE : NORM_ONE_N;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s3       <= sq_a_w;
			sq_b_s3       <= sq_b_w;
			tag_s3.corner <= corner_w;
			tag_s3.res    <= res_w;
		end
	end

	// Stage 4: sum of squares for the corner distance.
	logic                 v_s4;
	logic [SUM_BITS-1:0]  sum_s4;
	sq_tag_t              tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= SUM_BITS'(sq_a_s3) + SUM_BITS'(sq_b_s3);
			tag_s4 <= tag_s3;
		end
	end

	// Floor square root, one bit per stage.
	logic                 sq_valid;
	logic [ROOT_BITS-1:0] sq_root;
	sq_tag_t              sq_tag;

	rsd_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.radicand  (RAD_BITS'(sum_s4)),
		.in_tag    (tag_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	// Corner distance saturates to the largest positive distance.
	out_t                 push_data;
	logic [DIST_BITS-1:0] root_sat;

	assign root_sat = sq_root[ROOT_BITS-1] ? {1'b0, {(DIST_BITS-1){1'b1}}}
	                                       : DIST_BITS'(sq_root[ROOT_BITS-2:0]);

	always_comb begin
		push_data = sq_tag.res;
		if (sq_tag.corner) begin
			push_data.distance = $signed(root_sat);
		end
	end

	rsd_out_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sq_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTH
	// The pipeline only freezes while a finished result is waiting at the output.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("pipeline frozen with no result waiting at the output");

	// A frozen pipeline holds its valid bits.
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(v_s1) && $stable(v_s4) && $stable(sq_valid)))
		else $error("pipeline valid bits moved during a stall");

	// Every result carries a nonzero normal; a diagonal one on both axes.
	a_normal_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.normal_x != NORM_ZERO) || (out_data.normal_y != NORM_ZERO)))
		else $error("result with a zero normal");

	a_diag_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((out_data.normal_x == NORM_DIAG) || (out_data.normal_x == NORM_DIAG_N)))
		|-> ((out_data.normal_y == NORM_DIAG) || (out_data.normal_y == NORM_DIAG_N)))
		else $error("corner result with a mismatched normal");
`endif

endmodule

FILE: tb/tb_rect_signed_distance_exit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rect_signed_distance_exit
// Self-checking bench for the rectangle signed-distance block. A scoreboard
// class keeps its own copy of the rectangle edges and works out the distance,
// exit point and outward normal of every accepted point. Each result beat is
// compared field by field, in order. The run goes through directed corner
// cases and then random rectangles and points. Sender gaps and receiver stalls
// vary from phase to phase, and one long receiver hold-off backs up the
// pipeline.
// ----------------------------------------------------------------------------
module tb_rect_signed_distance_exit;
	import rsd_pkg::*;

	localparam longint COORD_LO    = -(longint'(1) << (COORD_BITS - 1));
	localparam longint COORD_HI    = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint DIST_MAX    = (longint'(1) << (DIST_BITS - 1)) - 1;
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     TAIL_CYCLES = 40;
	localparam int     PHASE_ITEMS = 180;

	typedef enum {SIDE_X, SIDE_Y, SIDE_CORNER} exit_side_t;

	// Scoreboard: rectangle copy, expected exits in order, failure count.
	class rect_exit_checker;
		longint x_lo, y_lo, x_hi, y_hi;
		out_t pending_exits[$];
		int unsigned fail_count;

		function new();
			x_lo = EDGE_MIN_RST;
			y_lo = EDGE_MIN_RST;
			x_hi = EDGE_MAX_RST;
			y_hi = EDGE_MAX_RST;
			fail_count = 0;
		endfunction

		function void set_edge(cfg_reg_t idx, logic signed [COORD_BITS-1:0] v);
			longint value;
			value = v;
			case (idx)
				REG_X_MIN: x_lo = value;
				REG_Y_MIN: y_lo = value;
				REG_X_MAX: x_hi = value;
				REG_Y_MAX: y_hi = value;
				default: ;
			endcase
		endfunction

		// Floor of the Euclidean length, one root bit at a time.
		function longint floor_hypot(longint a, longint b);
			longint total, root, trial;
			total = a * a + b * b;
			root = 0;
			for (int k = 27; k >= 0; k--) begin
				trial = root | (longint'(1) << k);
				if (trial * trial <= total)
					root = trial;
			end
			return root;
		endfunction

		// All math runs on doubled coordinates, so every halving is exact.
		function out_t nearest_exit(in_t p);
			longint px, py, cx2, cy2, hx2, hy2, dx2, dy2, ex2, ey2, dist_val;
			bit right, up;
			exit_side_t side;
			out_t res;
			px = longint'(p.point_x);
			py = longint'(p.point_y);
			cx2 = x_lo + x_hi;
			cy2 = y_lo + y_hi;
			hx2 = x_hi - x_lo;
			hy2 = y_hi - y_lo;
			dx2 = 2 * px - cx2;
			dy2 = 2 * py - cy2;
			if (dx2 < 0)
				dx2 = -dx2;
			if (dy2 < 0)
				dy2 = -dy2;
			ex2 = dx2 - hx2;
			ey2 = dy2 - hy2;
			// A point on a centre line counts as left or below.
			right = (2 * px) > cx2;
			up = (2 * py) > cy2;

			// Inside, a tie between the two sides goes to the horizontal side.
			if (dx2 <= hx2 && dy2 <= hy2)
				side = (ex2 > ey2) ? SIDE_X : SIDE_Y;
			else if (dx2 > hx2)
				side = (dy2 > hy2) ? SIDE_CORNER : SIDE_X;
			else
				side = SIDE_Y;

			res.exit_x = p.point_x;
			res.exit_y = p.point_y;
			res.normal_x = NORM_ZERO;
			res.normal_y = NORM_ZERO;
			case (side)
				SIDE_X: begin
					dist_val = ex2 >>> 1;
					res.exit_x = COORD_BITS'(right ? x_hi : x_lo);
					res.normal_x = right ? NORM_ONE : NORM_ONE_N;
				end
				SIDE_Y: begin
					dist_val = ey2 >>> 1;
					res.exit_y = COORD_BITS'(up ? y_hi : y_lo);
					res.normal_y = up ? NORM_ONE : NORM_ONE_N;
				end
				default: begin
					dist_val = floor_hypot(ex2 >>> 1, ey2 >>> 1);
					res.exit_x = COORD_BITS'(right ? x_hi : x_lo);
					res.exit_y = COORD_BITS'(up ? y_hi : y_lo);
					res.normal_x = right ? NORM_DIAG : NORM_DIAG_N;
					res.normal_y = up ? NORM_DIAG : NORM_DIAG_N;
				end
			endcase

			// Saturate to the distance field.
			if (dist_val > DIST_MAX)
				dist_val = DIST_MAX;
			if (dist_val < -DIST_MAX - 1)
				dist_val = -DIST_MAX - 1;
			res.distance = DIST_BITS'(dist_val);
			return res;
		endfunction

		function void note_point(in_t p);
			pending_exits.push_back(nearest_exit(p));
		endfunction

		function void check_result(out_t got);
			out_t want;
			bit bad;
			if (pending_exits.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result beat with nothing expected: dist %0d exit (%0d,%0d)",
						got.distance, got.exit_x, got.exit_y);
				return;
			end
			want = pending_exits.pop_front();
			bad = (got.distance !== want.distance) || (got.exit_x !== want.exit_x) ||
				(got.exit_y !== want.exit_y) || (got.normal_x !== want.normal_x) ||
				(got.normal_y !== want.normal_y);
			if (bad) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch: expected dist %0d exit (%0d,%0d) normal (%0d,%0d)",
						want.distance, want.exit_x, want.exit_y, want.normal_x, want.normal_y);
					$display("          actual   dist %0d exit (%0d,%0d) normal (%0d,%0d)",
						got.distance, got.exit_x, got.exit_y, got.normal_x, got.normal_y);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	rect_exit_checker rect_board;
	int unsigned gap_pct;
	int unsigned stall_pct;
	bit hold_off;
	int unsigned cycle_count;

	rect_signed_distance_exit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Receiver: random stalls, or a solid hold-off when one is running.
	initial out_ready = 1'b0;
	always @(negedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// Result beats are checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			rect_board.check_result(out_data);
	end

	// Run-time guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rect_signed_distance_exit: errors");
			$finish;
		end
	end

	task automatic write_edge(cfg_reg_t idx, longint v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= COORD_BITS'(v);
		do @(posedge clk); while (!cfg_ready);
		rect_board.set_edge(idx, COORD_BITS'(v));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rectangle(longint xl, longint yl, longint xh, longint yh);
		write_edge(REG_X_MIN, xl);
		write_edge(REG_Y_MIN, yl);
		write_edge(REG_X_MAX, xh);
		write_edge(REG_Y_MAX, yh);
	endtask

	task automatic send_point(in_t p);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		rect_board.note_point(p);
	endtask

	task automatic send_xy(longint x, longint y);
		in_t p;
		p.point_x = COORD_BITS'(x);
		p.point_y = COORD_BITS'(y);
		send_point(p);
	endtask

	// Stop offering points and wait until every expected result is back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rect_board.pending_exits.size() != 0)
			@(posedge clk);
	endtask

	task automatic hold_stretch(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// One coordinate: full range, on an edge or centre line, or near the box.
	function automatic longint coord_near(longint lo, longint hi);
		longint a, b, span, mid;
		int unsigned r;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		span = b - a + 1;
		mid = (lo + hi) >>> 1;
		r = $urandom_range(99);
		if (r < 12)
			return longint'($urandom());
		if (r < 30) begin
			case ($urandom_range(3))
				0: return lo + longint'($urandom_range(2)) - 1;
				1: return hi + longint'($urandom_range(2)) - 1;
				2: return mid;
				default: return mid + 1;
			endcase
		end
		return a - span / 2 + longint'($urandom_range(32'(2 * span)));
	endfunction

	function automatic in_t pick_point();
		in_t p;
		p.point_x = COORD_BITS'(coord_near(rect_board.x_lo, rect_board.x_hi));
		p.point_y = COORD_BITS'(coord_near(rect_board.y_lo, rect_board.y_hi));
		return p;
	endfunction

	task automatic run_points(int count);
		for (int i = 0; i < count; i++) begin
			while ($urandom_range(99) < gap_pct) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			send_point(pick_point());
		end
	endtask

	// Rectangle shapes: small box, fully random (may be inverted),
	// degenerate on x, and a wide box.
	task automatic pick_rectangle(int kind);
		longint w, h, x0, y0;
		case (kind)
			0: begin
				w = $urandom_range(1 << 16);
				h = $urandom_range(1 << 16);
				x0 = COORD_LO + longint'($urandom_range(32'((1 << COORD_BITS) - 1 - w)));
				y0 = COORD_LO + longint'($urandom_range(32'((1 << COORD_BITS) - 1 - h)));
				set_rectangle(x0, y0, x0 + w, y0 + h);
			end
			1: set_rectangle($urandom(), $urandom(), $urandom(), $urandom());
			2: begin
				h = $urandom_range(1 << 12);
				x0 = longint'($signed(COORD_BITS'($urandom())));
				y0 = COORD_LO + longint'($urandom_range(32'((1 << COORD_BITS) - 1 - h)));
				set_rectangle(x0, y0, x0, y0 + h);
			end
			default: begin
				w = $urandom_range(1 << 23);
				h = $urandom_range(1 << 23);
				x0 = COORD_LO + longint'($urandom_range(32'((1 << COORD_BITS) - 1 - w)));
				y0 = COORD_LO + longint'($urandom_range(32'((1 << COORD_BITS) - 1 - h)));
				set_rectangle(x0, y0, x0 + w, y0 + h);
			end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_X_MIN;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		cycle_count = 0;
		rect_board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset rectangle: centre, diagonal tie, each side inside and out,
		// edge and corner points, corner regions, and the coordinate extremes.
		send_xy(2048, 2048);
		send_xy(1024, 1024);
		send_xy(3072, 2048);
		send_xy(1024, 3072);
		send_xy(0, 2048);
		send_xy(4096, 4096);
		send_xy(5000, 2048);
		send_xy(-3000, 2048);
		send_xy(2048, 8000);
		send_xy(2048, -100);
		send_xy(6000, 7000);
		send_xy(-500, -700);
		send_xy(-4096, 5000);
		send_xy(9000, -1);
		send_xy(COORD_LO, COORD_LO);
		send_xy(COORD_HI, COORD_HI);
		send_xy(COORD_LO, COORD_HI);
		send_xy(COORD_HI, COORD_LO);
		settle();

		// Rectangle spanning the whole coordinate range.
		set_rectangle(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
		send_xy(COORD_LO, COORD_HI);
		send_xy(COORD_HI, COORD_LO);
		send_xy(0, 0);
		send_xy(-1, -1);
		settle();

		// Fully inverted rectangle: the largest corner distances.
		set_rectangle(COORD_HI, COORD_HI, COORD_LO, COORD_LO);
		send_xy(COORD_HI, COORD_HI);
		send_xy(COORD_LO, COORD_LO);
		send_xy(0, -1);
		settle();

		// Random phases; one of them holds the receiver off for a long time.
		for (int k = 0; k < 8; k++) begin
			pick_rectangle(k % 4);
			case (k % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 64; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 64; end
				default: begin gap_pct = 19; stall_pct = 19; end
			endcase
			if (k == 4) begin
				fork
					hold_stretch(400);
					run_points(PHASE_ITEMS);
				join
			end else begin
				run_points(PHASE_ITEMS);
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (rect_board.fail_count == 0 && rect_board.pending_exits.size() == 0) begin
			$display("tb_rect_signed_distance_exit: clean");
		end else begin
			if (rect_board.pending_exits.size() != 0)
				$display("%0d expected results never arrived", rect_board.pending_exits.size());
			$display("tb_rect_signed_distance_exit: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/rsd_pkg.sv
rtl/rsd_sqrt_pipe.sv
rtl/rsd_out_skid.sv
rtl/rect_signed_distance_exit.sv
tb/tb_rect_signed_distance_exit.sv
